[rtl/aons_pkg.sv]
// aons_pkg: shared types, name patterns and hit/flag codes for the AML object name scanner.
// Used by every module of the scanner; no dependencies.
`default_nettype none

package aons_pkg;

   localparam int NAME_COUNT = 12;
   localparam int WIN_BYTES  = 8;   // longest name is eight bytes
   localparam int HIT_W      = 9;
   localparam int FLAG_W     = 5;
   localparam int BAT_COUNT  = 4;

   // blob hit bits
   localparam int HIT_PNP0C0A = 4;
   localparam int HIT_AC      = 5;
   localparam int HIT_EC      = 6;
   localparam int HIT_BIF     = 7;
   localparam int HIT_BST     = 8;

   // sticky flag bits
   localparam int FLAG_BATTERY = 0;
   localparam int FLAG_AC      = 1;
   localparam int FLAG_EC      = 2;
   localparam int FLAG_BIF     = 3;
   localparam int FLAG_BST     = 4;

   localparam logic [2:0] FIRST_NONE = 3'd4;

   // newest byte of the window sits in the low byte, as does the last char of each name
   localparam logic [63:0] NAME_PATTERN [NAME_COUNT] = '{
      64'("BAT0"), 64'("BAT1"), 64'("BAT2"), 64'("BAT3"),
      64'("PNP0C0A"), 64'("ACPI0003"), 64'("ACAD"), 64'("ADP1"),
      64'("PNP0C09"), 64'("_BIF"), 64'("_BIX"), 64'("_BST")
   };
   localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
      4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd8, 4'd4, 4'd4, 4'd7, 4'd4, 4'd4, 4'd4
   };
   localparam logic [3:0] NAME_HIT_BIT [NAME_COUNT] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6, 4'd7, 4'd7, 4'd8
   };

   typedef struct packed {
      logic             valid;
      logic [HIT_W-1:0] hits;
   } commit_req_type;

   typedef struct packed {
      logic       battery_present;
      logic [2:0] battery_count;
      logic [2:0] first_battery;
      logic       ac_present;
      logic       ec_present;
      logic       bif_present;
      logic       bst_present;
   } status_type;

   // per-name compare of one window byte; names shorter than the position don't care
   function automatic logic [NAME_COUNT-1:0] pos_match(input logic [7:0] b,
                                                       input logic [2:0] pos);
      logic [NAME_COUNT-1:0] m;
      m = '0;
      for (int k = 0; k < NAME_COUNT; k++) begin
         if ({1'b0, pos} < NAME_LEN[k]) begin
            m[k] = (b == NAME_PATTERN[k][8*int'(pos) +: 8]);
         end else begin
            m[k] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage : aons_pkg

`default_nettype wire

[rtl/aml_object_name_scanner_core.sv]
// aml_object_name_scanner_core: top level of the AML object name scanner.
// Depends on aons_pkg, aons_byte_cell and aons_commit_unit.
//
//   channel | dir | tdata                    | tuser | tlast
//   req     | in  | [7:0] data_byte          | -     | last_of_blob
//   rsp     | out | [0] battery_present, [3:1] battery_count, [6:4] first_battery,
//           |     | [7] ac_present, [8] ec_present, [9] bif_present, [10] bst_present
//
// One byte per cycle while no rsp word is stalled; each accepted word yields one rsp word on the next cycle.
// The window is the newest byte plus a seven-cell chain, and every name is compared against it at once.
// Reset clears the window, blob count/hits and all sticky state at once.
// req_tready drops only while a rsp word is held and rsp_tready is low.
`default_nettype none

module aml_object_name_scanner_core
   import aons_pkg::*;
#(
   parameter int MIN_BLOB_LEN = 36
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata    // battery_present, battery_count, first_battery,
                                         // ac_present, ec_present, bif_present, bst_present
);

   localparam int CNT_W = $clog2(MIN_BLOB_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_BLOB_LEN);

   logic                  accept;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in, cnt_next;
   logic [HIT_W-1:0]      hits_ff, hits_in, hits_now;
   logic [NAME_COUNT-1:0] name_hit;
   logic [NAME_COUNT-1:0] match [WIN_BYTES];
   logic [7:0]            win_byte [WIN_BYTES];
   commit_req_type        commit;
   status_type            status;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign win_byte[0] = req_tdata;
   assign match[0]    = pos_match(req_tdata, 3'd0);

   for (genvar p = 1; p < WIN_BYTES; p++) begin : g_cell
      aons_byte_cell #(
         .POSITION (p)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (accept),
         .clear    (accept && req_tlast),
         .byte_in  (win_byte[p-1]),
         .byte_out (win_byte[p]),
         .match    (match[p])
      );
   end

   // a name hits when every window position agrees; cleared cells hold zero,
   // which no name contains, so partial windows never match
   always_comb begin
      name_hit = '1;
      for (int p = 0; p < WIN_BYTES; p++) begin
         name_hit = name_hit & match[p];
      end
      hits_now = '0;
      for (int k = 0; k < NAME_COUNT; k++) begin
         hits_now[NAME_HIT_BIT[k]] = hits_now[NAME_HIT_BIT[k]] | name_hit[k];
      end
   end

   assign cnt_next = (cnt_ff == CNT_MIN) ? cnt_ff : cnt_ff + 1'b1;

   always_comb begin
      cnt_in  = cnt_ff;
      hits_in = hits_ff;
      if (accept) begin
         if (req_tlast) begin
            cnt_in  = '0;
            hits_in = '0;
         end else begin
            cnt_in  = cnt_next;
            hits_in = hits_ff | hits_now;
         end
      end
   end

   always_comb begin
      commit.valid = accept && req_tlast && (cnt_next == CNT_MIN);
      commit.hits  = hits_ff | hits_now;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   aons_commit_unit u_commit (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .status (status)
   );

   // committed state only moves on accept, so it doubles as the held rsp word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, status.bst_present, status.bif_present,
                        status.ec_present, status.ac_present, status.first_battery,
                        status.battery_count, status.battery_present};

endmodule : aml_object_name_scanner_core

`default_nettype wire

[rtl/aons_byte_cell.sv]
// aons_byte_cell: one stage of the byte window; holds a byte, passes it on, compares it
// against every name character expected at its position. Depends on aons_pkg.
`default_nettype none

module aons_byte_cell
   import aons_pkg::*;
#(
   parameter int POSITION = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift,
   input  wire logic                  clear,
   input  wire logic [7:0]            byte_in,
   output logic      [7:0]            byte_out,
   output logic      [NAME_COUNT-1:0] match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_next_in;

   always_comb begin
      byte_next_in = byte_ff;
      if (clear) begin
         byte_next_in = '0;
      end else if (shift) begin
         byte_next_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_next_in;
      end
   end

   assign byte_out = byte_ff;
   assign match    = pos_match(byte_ff, 3'(POSITION));

endmodule : aons_byte_cell

`default_nettype wire

[rtl/aons_commit_unit.sv]
// aons_commit_unit: sticky battery/AC/EC/method flags, BATn mask and first battery index,
// updated when a blob's hits commit. Depends on aons_pkg.
`default_nettype none

module aons_commit_unit
   import aons_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire commit_req_type commit,
   output status_type          status
);

   logic [BAT_COUNT-1:0] mask_ff,   mask_in;
   logic [2:0]           first_ff,  first_in;
   logic [FLAG_W-1:0]    sticky_ff, sticky_in;
   logic [BAT_COUNT-1:0] new_bat;
   logic [2:0]           lowest_new;

   assign new_bat = commit.hits[BAT_COUNT-1:0] & ~mask_ff;

   always_comb begin
      lowest_new = FIRST_NONE;
      for (int b = BAT_COUNT - 1; b >= 0; b--) begin
         if (new_bat[b]) begin
            lowest_new = 3'(b);
         end
      end
   end

   always_comb begin
      mask_in   = mask_ff;
      first_in  = first_ff;
      sticky_in = sticky_ff;
      if (commit.valid) begin
         mask_in = mask_ff | new_bat;
         if ((mask_ff == '0) && (new_bat != '0)) begin
            first_in = lowest_new;
         end
         sticky_in[FLAG_BATTERY] = sticky_ff[FLAG_BATTERY] | (|new_bat)
                                   | commit.hits[HIT_PNP0C0A];
         sticky_in[FLAG_AC]  = sticky_ff[FLAG_AC]  | commit.hits[HIT_AC];
         sticky_in[FLAG_EC]  = sticky_ff[FLAG_EC]  | commit.hits[HIT_EC];
         sticky_in[FLAG_BIF] = sticky_ff[FLAG_BIF] | commit.hits[HIT_BIF];
         sticky_in[FLAG_BST] = sticky_ff[FLAG_BST] | commit.hits[HIT_BST];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         first_ff  <= FIRST_NONE;
         sticky_ff <= '0;
      end else begin
         mask_ff   <= mask_in;
         first_ff  <= first_in;
         sticky_ff <= sticky_in;
      end
   end

   always_comb begin
      status.battery_present = sticky_ff[FLAG_BATTERY];
      status.battery_count   = 3'({2'b00, mask_ff[0]} + {2'b00, mask_ff[1]}
                                  + {2'b00, mask_ff[2]} + {2'b00, mask_ff[3]});
      status.first_battery   = first_ff;
      status.ac_present      = sticky_ff[FLAG_AC];
      status.ec_present      = sticky_ff[FLAG_EC];
      status.bif_present     = sticky_ff[FLAG_BIF];
      status.bst_present     = sticky_ff[FLAG_BST];
   end

endmodule : aons_commit_unit

`default_nettype wire

[rtl/aons_checker.sv]
// aons_checker: port-level checks for aml_object_name_scanner_core, bound to the top level.
// Depends on aons_pkg and the top level's ports.
`default_nettype none

module aons_checker
   import aons_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // stalled rsp word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // input only backs up behind a stalled rsp word
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without rsp stall");

   // every accepted req word shows up as a rsp word on the next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted req word without rsp word");

   // a counted battery implies a chosen name and the battery flag
   a_count_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:1] != 3'd0) |->
         rsp_tdata[0] && (rsp_tdata[6:4] != FIRST_NONE))
      else $error("battery count without name or present flag");

   // battery flag is sticky across rsp words
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $past(rsp_tvalid) && $past(rsp_tdata[0]) |-> rsp_tdata[0])
      else $error("battery_present cleared");

endmodule : aons_checker

bind aml_object_name_scanner_core aons_checker u_aons_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[bench/tb_aml_object_name_scanner_core.sv]
// Testbench for aml_object_name_scanner_core: streams table blobs byte by byte and checks
// every status word against a scoreboard that rescans the bytes on its own.
// Depends on aons_pkg and the scanner RTL.
module tb_aml_object_name_scanner_core;
   import aons_pkg::*;

   localparam int BLOB_MIN    = 36;
   localparam int BYTE_TARGET = 900;
   localparam int QUIET_AFTER = 700;   // no idling on either side in blobs begun past this many bytes

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   bit idle_on = 1'b1;
   int carry_name = -1;   // name whose head closed the previous blob
   int carry_at;

   class name_scan_scoreboard;
      status_type           expected_status [$];
      logic [63:0]          pattern [NAME_COUNT];
      int unsigned          pat_len [NAME_COUNT];
      int unsigned          pat_hit [NAME_COUNT];
      logic [55:0]          window;
      int unsigned          blob_len;
      logic [HIT_W-1:0]     blob_hits;
      logic [BAT_COUNT-1:0] bat_mask;
      logic [2:0]           first_bat;
      logic [FLAG_W-1:0]    flags;
      int                   errors, bytes_seen, blobs_seen, blobs_committed;

      function new();
         string text [NAME_COUNT];
         text = '{"BAT0", "BAT1", "BAT2", "BAT3", "PNP0C0A", "ACPI0003",
                  "ACAD", "ADP1", "PNP0C09", "_BIF", "_BIX", "_BST"};
         pat_hit = '{0, 1, 2, 3, HIT_PNP0C0A, HIT_AC, HIT_AC, HIT_AC, HIT_EC,
                     HIT_BIF, HIT_BIF, HIT_BST};
         for (int k = 0; k < NAME_COUNT; k++) begin
            pat_len[k] = text[k].len();
            pattern[k] = '0;
            for (int i = 0; i < text[k].len(); i++)
               pattern[k] = {pattern[k][55:0], 8'(text[k][i])};
         end
         window = '0;
         blob_len = 0;
         blob_hits = '0;
         bat_mask = '0;
         first_bat = FIRST_NONE;
         flags = '0;
         errors = 0;
         bytes_seen = 0;
         blobs_seen = 0;
         blobs_committed = 0;
      endfunction

      function void commit_blob(logic [HIT_W-1:0] hits);
         bit was_empty;
         was_empty = (bat_mask == '0);
         for (int n = 0; n < BAT_COUNT; n++) begin
            if (hits[n] && !bat_mask[n]) begin
               // only the lowest new name of the very first battery commit is kept
               if (was_empty && bat_mask == '0) first_bat = 3'(n);
               bat_mask[n] = 1'b1;
               flags[FLAG_BATTERY] = 1'b1;
            end
         end
         if (hits[HIT_PNP0C0A]) flags[FLAG_BATTERY] = 1'b1;
         if (hits[HIT_AC])      flags[FLAG_AC]      = 1'b1;
         if (hits[HIT_EC])      flags[FLAG_EC]      = 1'b1;
         if (hits[HIT_BIF])     flags[FLAG_BIF]     = 1'b1;
         if (hits[HIT_BST])     flags[FLAG_BST]     = 1'b1;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [63:0] w, mask;
         int unsigned got;
         status_type s;
         w = {window, b};
         got = (blob_len + 1 > BLOB_MIN) ? BLOB_MIN : blob_len + 1;
         for (int k = 0; k < NAME_COUNT; k++) begin
            mask = (pat_len[k] >= 8) ? '1 : ((64'd1 << (8 * pat_len[k])) - 64'd1);
            // a name only counts once all its bytes belong to this blob
            if (got >= pat_len[k] && (w & mask) == pattern[k]) blob_hits[pat_hit[k]] = 1'b1;
         end
         bytes_seen++;
         if (last) begin
            blobs_seen++;
            if (got >= BLOB_MIN) begin
               commit_blob(blob_hits);
               blobs_committed++;
            end
            window = '0;
            blob_len = 0;
            blob_hits = '0;
         end else begin
            window = w[55:0];
            blob_len = got;
         end
         s.battery_present = flags[FLAG_BATTERY];
         s.battery_count   = 3'($countones(bat_mask));
         s.first_battery   = first_bat;
         s.ac_present      = flags[FLAG_AC];
         s.ec_present      = flags[FLAG_EC];
         s.bif_present     = flags[FLAG_BIF];
         s.bst_present     = flags[FLAG_BST];
         expected_status.push_back(s);
      endfunction

      function void check_status(logic [15:0] word);
         status_type want;
         if (expected_status.size() == 0) begin
            $error("status word %h with nothing expected", word);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         if (word[0] !== want.battery_present) begin
            $error("battery_present: expected %0d, actual %0d", want.battery_present, word[0]);
            errors++;
         end
         if (word[3:1] !== want.battery_count) begin
            $error("battery_count: expected %0d, actual %0d", want.battery_count, word[3:1]);
            errors++;
         end
         if (word[6:4] !== want.first_battery) begin
            $error("first_battery: expected %0d, actual %0d", want.first_battery, word[6:4]);
            errors++;
         end
         if (word[7] !== want.ac_present) begin
            $error("ac_present: expected %0d, actual %0d", want.ac_present, word[7]);
            errors++;
         end
         if (word[8] !== want.ec_present) begin
            $error("ec_present: expected %0d, actual %0d", want.ec_present, word[8]);
            errors++;
         end
         if (word[9] !== want.bif_present) begin
            $error("bif_present: expected %0d, actual %0d", want.bif_present, word[9]);
            errors++;
         end
         if (word[10] !== want.bst_present) begin
            $error("bst_present: expected %0d, actual %0d", want.bst_present, word[10]);
            errors++;
         end
         if (word[15:11] !== 5'd0) begin
            $error("pad: expected 0, actual %0h", word[15:11]);
            errors++;
         end
      endfunction
   endclass

   name_scan_scoreboard sb;

   aml_object_name_scanner_core #(
      .MIN_BLOB_LEN(BLOB_MIN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] name_byte(int k, int i);
      return sb.pattern[k][8 * (sb.pat_len[k] - 1 - i) +: 8];
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, last);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), i == s.len() - 1);
   endtask

   task automatic random_blob(input int len, input int names_in);
      logic [7:0] q [$];
      string alpha;
      int k, at, span;
      alpha = "ABCDINPSTX_0139";
      q = {};
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 1)) q.push_back(8'(alpha[$urandom_range(0, alpha.len() - 1)]));
         else q.push_back(8'($urandom_range(0, 255)));
      end
      // tail of a name whose head ended the previous blob
      if (carry_name >= 0) begin
         for (int i = carry_at; i < sb.pat_len[carry_name]; i++)
            if (i - carry_at < len) q[i - carry_at] = name_byte(carry_name, i);
         carry_name = -1;
      end
      repeat (names_in) begin
         k = $urandom_range(0, NAME_COUNT - 1);
         span = sb.pat_len[k];
         case ($urandom_range(0, 3))
            0: at = 0;
            1: at = len - span;
            default: at = $urandom_range(0, len - 1);
         endcase
         if (at < 0) at = 0;
         for (int i = 0; i < span; i++)
            if (at + i < len) q[at + i] = name_byte(k, i);
      end
      if ($urandom_range(0, 7) == 0) begin
         k = $urandom_range(0, NAME_COUNT - 1);
         at = $urandom_range(1, sb.pat_len[k] - 1);
         for (int i = 0; i < at; i++)
            if (len - at + i >= 0) q[len - at + i] = name_byte(k, i);
         carry_name = k;
         carry_at = at;
      end
      for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
   endtask

   // result side: check accepted words, stall in bursts
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int len, names_in, wait_cycles;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes, names cut by blob ends, names in blobs too short to commit
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_text("_BST");
      send_text("AC");
      send_text("AD");
      send_text("ACPI0003");
      send_text("PNP0");
      send_text("C0A");

      // hold off until every status word is back
      req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0) @(posedge clock);

      while (sb.bytes_seen < BYTE_TARGET) begin
         idle_on = (sb.bytes_seen < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: len = $urandom_range(1, BLOB_MIN - 1);
            4:          len = $urandom_range(BLOB_MIN - 1, BLOB_MIN);
            default:    len = $urandom_range(BLOB_MIN, BLOB_MIN + 14);
         endcase
         names_in = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
         random_blob(len, names_in);
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (sb.expected_status.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (sb.expected_status.size() != 0) begin
         $error("%0d status words never arrived", sb.expected_status.size());
         sb.errors++;
      end
      repeat (4) @(posedge clock);

      $display("Scanned %0d bytes in %0d blobs, %0d long enough to commit;",
               sb.bytes_seen, sb.blobs_seen, sb.blobs_committed);
      $display("final battery mask %b, first battery %0d, flags %b, %0d mismatches.",
               sb.bat_mask, sb.first_bat, sb.flags, sb.errors);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
